### src/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the scope trace plotter.
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int COLUMNS_DEFAULT = 320;
   localparam int ROWS_DEFAULT    = 240;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 3;
   localparam int COLOR_W  = 8;
   localparam int LED_W    = 7;
   localparam int KIND_W   = 2;

   // sample / 274 == ((sample >> 1) * 30616) >> 22, exact over 16 bits
   localparam int                DIV_PRE_W = SAMPLE_W - 1;
   localparam logic [DIV_PRE_W-1:0] DIV_MULT = 15'd30616;
   localparam int                DIV_SHIFT = 22;
   localparam int                PROD_W    = 2 * DIV_PRE_W;
   localparam int                QUOT_W    = PROD_W - DIV_SHIFT;

   localparam logic [COLOR_W-1:0] TRACE_COLOR_RESET      = 8'd252;
   localparam logic [COLOR_W-1:0] GRID_COLOR_RESET       = 8'd3;
   localparam logic [COLOR_W-1:0] AXIS_COLOR_RESET       = 8'd73;
   localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RESET = 8'd0;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_TRACE_COLOR      = 2'd0,
      REG_GRID_COLOR       = 2'd1,
      REG_AXIS_COLOR       = 2'd2,
      REG_BACKGROUND_COLOR = 2'd3
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_VLINE = 2'd2
   } cmd_kind_type;

   // per-sample command slots, emitted lowest first
   localparam int STEP_CLEAR = 0;
   localparam int STEP_ERASE = 1;
   localparam int STEP_GRID  = 2;
   localparam int STEP_AXIS  = 3;
   localparam int STEP_TRACE = 4;
   localparam int NUM_STEPS  = 5;

endpackage
`default_nettype wire

### src/stp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 320
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/scope_trace_plotter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_trace_plotter_core
// Sweeping oscilloscope trace plotter: turns converter samples into draw
// commands (clear, erase pixel, grid/axis lines, trace pixel).
//
// Input channel req_*: one beat per converter sample plus gain code.
// Result channel rsp_*: 2 to 4 command beats per sample, last one flagged
// by rsp_last_cmd. Order: clear, erase, grid line, axis line, trace pixel.
// Config port: APB-style, four 8-bit colour registers at 0x0..0xC.
// Stages: sample staged in stage 1, then command queue, then output register.
// Throughput: one command beat per cycle through the output register while
// the receiver does not stall; the next sample is taken while the current
// one drains, and its row RAM read overlaps.
// Stored rows live in a COLUMNS-deep RAM; a fill count marks the written
// prefix, unwritten columns read as ROWS/2. No clearing pass at reset.
// Reset: colours to defaults, sweep to column 0, next sample gives a clear.
// When the receiver stalls, the output beat holds and req_stall rises once
// the staging register and command queue are both occupied.
// ----------------------------------------------------------------------------
module scope_trace_plotter_core #(
   parameter int COLUMNS = stp_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = stp_pkg::ROWS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [stp_pkg::SAMPLE_W-1:0]      req_adc_sample,
   input  wire logic [stp_pkg::GAIN_W-1:0]        req_gain_code,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [stp_pkg::KIND_W-1:0]        rsp_cmd_kind,
   output logic      [$clog2(COLUMNS)-1:0]        rsp_pos_x,
   output logic      [$clog2(ROWS)-1:0]           rsp_pos_y,
   output logic      [stp_pkg::COLOR_W-1:0]       rsp_color,
   output logic      [stp_pkg::GAIN_W-1:0]        rsp_gain_out,
   output logic      [stp_pkg::LED_W-1:0]         rsp_led_value,
   output logic                                   rsp_last_cmd,
   // config port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [stp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [stp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [stp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   localparam int XW        = $clog2(COLUMNS);
   localparam int YW        = $clog2(ROWS);
   localparam int FW        = $clog2(COLUMNS + 1);
   localparam int GRID_ROW  = ROWS / 8;
   localparam int GRID_COL  = COLUMNS / 10;
   localparam int NROW_MULT = (ROWS - 1) / GRID_ROW;
   localparam int NCOL_MULT = (COLUMNS - 1) / GRID_COL;
   localparam int MID_ROW   = ROWS / 2;
   localparam int MID_COL   = COLUMNS / 2;
   localparam int CMPW      = ((YW > stp_pkg::QUOT_W) ? YW : stp_pkg::QUOT_W) + 1;
   localparam int NS        = stp_pkg::NUM_STEPS;
   localparam int CW        = stp_pkg::COLOR_W;
   localparam int GW        = stp_pkg::GAIN_W;
   localparam int LW        = stp_pkg::LED_W;

   // ---------------- config registers ----------------
   logic [CW-1:0] trace_color_ff, grid_color_ff, axis_color_ff, background_color_ff;
   logic          csr_write;
   stp_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = stp_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_color_ff      <= stp_pkg::TRACE_COLOR_RESET;
         grid_color_ff       <= stp_pkg::GRID_COLOR_RESET;
         axis_color_ff       <= stp_pkg::AXIS_COLOR_RESET;
         background_color_ff <= stp_pkg::BACKGROUND_COLOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            stp_pkg::REG_TRACE_COLOR:      trace_color_ff      <= pwdata[CW-1:0];
            stp_pkg::REG_GRID_COLOR:       grid_color_ff       <= pwdata[CW-1:0];
            stp_pkg::REG_AXIS_COLOR:       axis_color_ff       <= pwdata[CW-1:0];
            stp_pkg::REG_BACKGROUND_COLOR: background_color_ff <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (csr_index)
         stp_pkg::REG_TRACE_COLOR:      prdata[CW-1:0] = trace_color_ff;
         stp_pkg::REG_GRID_COLOR:       prdata[CW-1:0] = grid_color_ff;
         stp_pkg::REG_AXIS_COLOR:       prdata[CW-1:0] = axis_color_ff;
         stp_pkg::REG_BACKGROUND_COLOR: prdata[CW-1:0] = background_color_ff;
         default:                       prdata = '0;
      endcase
   end

   // ---------------- accept stage ----------------
   logic          accept;
   logic          started_ff;
   logic [GW-1:0] held_gain_ff;
   logic [XW-1:0] sweep_ff;
   logic          acc_clear;
   logic [XW-1:0] acc_x, acc_next;
   logic [XW+6:0] acc_led_wide;
   logic [NS-1:0] acc_mask;
   logic          acc_on_grid_col;
   logic [stp_pkg::PROD_W-1:0] acc_prod;

   assign accept = req_valid && !req_stall;

   always_comb begin
      acc_clear = !started_ff || (req_gain_code != held_gain_ff);
      acc_x     = acc_clear ? '0 : sweep_ff;
      acc_next  = (acc_x == XW'(COLUMNS - 1)) ? '0 : acc_x + XW'(1);
      acc_led_wide = ((XW + 7)'(req_gain_code) << 4) | (XW + 7)'(acc_next >> 5);
      acc_on_grid_col = 1'b0;
      for (int k = 0; k <= NCOL_MULT; k++) begin
         if (acc_x == XW'(k * GRID_COL)) acc_on_grid_col = 1'b1;
      end
      acc_mask = '0;
      acc_mask[stp_pkg::STEP_CLEAR] = acc_clear;
      acc_mask[stp_pkg::STEP_ERASE] = 1'b1;
      acc_mask[stp_pkg::STEP_GRID]  = acc_on_grid_col;
      acc_mask[stp_pkg::STEP_AXIS]  = (acc_x == XW'(MID_COL));
      acc_mask[stp_pkg::STEP_TRACE] = 1'b1;
      acc_prod = stp_pkg::PROD_W'(req_adc_sample >> 1) * stp_pkg::PROD_W'(stp_pkg::DIV_MULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         held_gain_ff <= '0;
         sweep_ff     <= '0;
      end else if (accept) begin
         started_ff   <= 1'b1;
         held_gain_ff <= req_gain_code;
         sweep_ff     <= acc_next;
      end
   end

   // ---------------- stage 1: row RAM read, new row ----------------
   logic                       s1_valid_ff;
   logic [XW-1:0]              s1_x_ff;
   logic [NS-1:0]              s1_mask_ff;
   logic [stp_pkg::PROD_W-1:0] s1_prod_ff;
   logic [GW-1:0]              s1_gain_ff;
   logic [LW-1:0]              s1_led_ff;
   logic                       s1_move;

   logic [YW-1:0] ram_rd_data;
   logic [FW-1:0] fill_ff;
   logic          lw_valid_ff;
   logic [XW-1:0] lw_x_ff;
   logic [YW-1:0] lw_y_ff;

   logic [stp_pkg::QUOT_W-1:0] s1_quot;
   logic [CMPW-1:0]            s1_quot_ext;
   logic [YW-1:0]              s1_new_y, s1_old_y;
   logic                       s1_old_on_grid;
   logic [CW-1:0]              s1_erase_color;

   stp_ram #(
      .WIDTH (YW),
      .DEPTH (COLUMNS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_x_ff),
      .wr_data (s1_new_y),
      .rd_en   (accept),
      .rd_addr (acc_x),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_quot     = stp_pkg::QUOT_W'(s1_prod_ff >> stp_pkg::DIV_SHIFT);
      s1_quot_ext = CMPW'(s1_quot);
      if (s1_quot_ext > CMPW'(ROWS - 1)) s1_new_y = '0;
      else s1_new_y = YW'(CMPW'(ROWS - 1) - s1_quot_ext);

      // write from the previous beat lands on the same edge as our read
      if (lw_valid_ff && (lw_x_ff == s1_x_ff)) s1_old_y = lw_y_ff;
      else if (FW'(s1_x_ff) < fill_ff) s1_old_y = ram_rd_data;
      else s1_old_y = YW'(MID_ROW);

      s1_old_on_grid = 1'b0;
      for (int k = 0; k <= NROW_MULT; k++) begin
         if (s1_old_y == YW'(k * GRID_ROW)) s1_old_on_grid = 1'b1;
      end
      if (s1_old_on_grid) s1_erase_color = grid_color_ff;
      else if (s1_old_y == YW'(MID_ROW)) s1_erase_color = axis_color_ff;
      else s1_erase_color = background_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_x_ff    <= acc_x;
         s1_mask_ff <= acc_mask;
         s1_prod_ff <= acc_prod;
         s1_gain_ff <= req_gain_code;
         s1_led_ff  <= acc_led_wide[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         lw_valid_ff <= 1'b0;
      end else if (s1_move) begin
         lw_valid_ff <= 1'b1;
         if (FW'(s1_x_ff) >= fill_ff) fill_ff <= FW'(s1_x_ff) + FW'(1);
      end
      if (s1_move) begin
         lw_x_ff <= s1_x_ff;
         lw_y_ff <= s1_new_y;
      end
   end

   // ---------------- command queue and output register ----------------
   logic [NS-1:0] mask_ff, mask_after, sel_bit;
   logic [XW-1:0] e_x_ff;
   logic [YW-1:0] e_old_y_ff, e_new_y_ff;
   logic [CW-1:0] e_erase_color_ff;
   logic [GW-1:0] e_gain_ff;
   logic [LW-1:0] e_led_ff;
   logic          out_load;

   stp_pkg::cmd_kind_type sel_kind;
   logic [XW-1:0]         sel_x;
   logic [YW-1:0]         sel_y;
   logic [CW-1:0]         sel_color;

   logic                  rsp_valid_ff;
   stp_pkg::cmd_kind_type rsp_cmd_kind_ff;
   logic [XW-1:0]         rsp_pos_x_ff;
   logic [YW-1:0]         rsp_pos_y_ff;
   logic [CW-1:0]         rsp_color_ff;
   logic [GW-1:0]         rsp_gain_out_ff;
   logic [LW-1:0]         rsp_led_value_ff;
   logic                  rsp_last_cmd_ff;

   always_comb begin
      sel_bit   = '0;
      sel_kind  = stp_pkg::CMD_PIXEL;
      sel_x     = e_x_ff;
      sel_y     = '0;
      sel_color = trace_color_ff;
      if (mask_ff[stp_pkg::STEP_CLEAR]) begin
         sel_bit[stp_pkg::STEP_CLEAR] = 1'b1;
         sel_kind  = stp_pkg::CMD_CLEAR;
         sel_x     = '0;
         sel_color = background_color_ff;
      end else if (mask_ff[stp_pkg::STEP_ERASE]) begin
         sel_bit[stp_pkg::STEP_ERASE] = 1'b1;
         sel_y     = e_old_y_ff;
         sel_color = e_erase_color_ff;
      end else if (mask_ff[stp_pkg::STEP_GRID]) begin
         sel_bit[stp_pkg::STEP_GRID] = 1'b1;
         sel_kind  = stp_pkg::CMD_VLINE;
         sel_color = grid_color_ff;
      end else if (mask_ff[stp_pkg::STEP_AXIS]) begin
         sel_bit[stp_pkg::STEP_AXIS] = 1'b1;
         sel_kind  = stp_pkg::CMD_VLINE;
         sel_color = axis_color_ff;
      end else begin
         sel_bit[stp_pkg::STEP_TRACE] = mask_ff[stp_pkg::STEP_TRACE];
         sel_y     = e_new_y_ff;
      end
      out_load   = (mask_ff != '0) && (!rsp_valid_ff || !rsp_stall);
      mask_after = out_load ? (mask_ff & ~sel_bit) : mask_ff;
      s1_move    = s1_valid_ff && (mask_after == '0);
      req_stall  = s1_valid_ff && !s1_move;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= s1_move ? s1_mask_ff : mask_after;
      end
      if (s1_move) begin
         e_x_ff           <= s1_x_ff;
         e_old_y_ff       <= s1_old_y;
         e_new_y_ff       <= s1_new_y;
         e_erase_color_ff <= s1_erase_color;
         e_gain_ff        <= s1_gain_ff;
         e_led_ff         <= s1_led_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= out_load;
      end
      if (out_load) begin
         rsp_cmd_kind_ff  <= sel_kind;
         rsp_pos_x_ff     <= sel_x;
         rsp_pos_y_ff     <= sel_y;
         rsp_color_ff     <= sel_color;
         rsp_gain_out_ff  <= e_gain_ff;
         rsp_led_value_ff <= e_led_ff;
         rsp_last_cmd_ff  <= (mask_after == '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cmd_kind  = rsp_cmd_kind_ff;
   assign rsp_pos_x     = rsp_pos_x_ff;
   assign rsp_pos_y     = rsp_pos_y_ff;
   assign rsp_color     = rsp_color_ff;
   assign rsp_gain_out  = rsp_gain_out_ff;
   assign rsp_led_value = rsp_led_value_ff;
   assign rsp_last_cmd  = rsp_last_cmd_ff;

   // ---------------- assertions ----------------
   a_s1_has_pixels: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_mask_ff[stp_pkg::STEP_ERASE] && s1_mask_ff[stp_pkg::STEP_TRACE]))
      else $error("staged sample lacks erase or trace command");

   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && mask_ff != '0))
      else $error("input stalled with empty command queue");

   a_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmd_kind_ff == stp_pkg::CMD_CLEAR) |-> !rsp_last_cmd_ff)
      else $error("clear command flagged as last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (fill_ff <= FW'(COLUMNS) && fill_ff > FW'(lw_x_ff)))
      else $error("fill count out of step with row writes");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (sweep_ff < XW'(COLUMNS) || sweep_ff == '0))
      else $error("sweep column beyond screen");

endmodule
`default_nettype wire

### verif/scope_trace_plotter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trace_plotter_checker
// Watches the sample, command and register ports of the trace plotter. It
// keeps its own copy of the column rows, sweep position, gain and colours,
// works out the draw commands each accepted sample must give, and matches
// every command beat against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module scope_trace_plotter_checker #(
   parameter int COLUMNS = stp_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = stp_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [stp_pkg::SAMPLE_W-1:0]      req_adc_sample,
   input  logic [stp_pkg::GAIN_W-1:0]        req_gain_code,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [stp_pkg::KIND_W-1:0]        rsp_cmd_kind,
   input  logic [$clog2(COLUMNS)-1:0]        rsp_pos_x,
   input  logic [$clog2(ROWS)-1:0]           rsp_pos_y,
   input  logic [stp_pkg::COLOR_W-1:0]       rsp_color,
   input  logic [stp_pkg::GAIN_W-1:0]        rsp_gain_out,
   input  logic [stp_pkg::LED_W-1:0]         rsp_led_value,
   input  logic                              rsp_last_cmd,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [stp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [stp_pkg::CSR_DATA_W-1:0]    pwdata,
   output int                                fail_count,
   output int                                pending_cmds
);

   localparam int XW = $clog2(COLUMNS);
   localparam int YW = $clog2(ROWS);
   localparam int SAMPLE_DIV = 274;

   typedef struct packed {
      stp_pkg::cmd_kind_type          kind;
      logic [XW-1:0]                  x;
      logic [YW-1:0]                  y;
      logic [stp_pkg::COLOR_W-1:0]    color;
      logic [stp_pkg::GAIN_W-1:0]     gain;
      logic [stp_pkg::LED_W-1:0]      led;
      logic                           last;
   } draw_cmd_type;

   logic [YW-1:0]               col_row [COLUMNS];
   int                          sweep;
   logic [stp_pkg::GAIN_W-1:0]  gain_held;
   bit                          running;
   logic [stp_pkg::COLOR_W-1:0] trace_c, grid_c, axis_c, bg_c;
   draw_cmd_type                expected_cmds[$];
   int                          errs = 0;

   function automatic draw_cmd_type make_cmd(stp_pkg::cmd_kind_type k, int x, int y,
                                             logic [stp_pkg::COLOR_W-1:0] c);
      draw_cmd_type d;
      d       = '0;
      d.kind  = k;
      d.x     = x[XW-1:0];
      d.y     = y[YW-1:0];
      d.color = c;
      return d;
   endfunction

   function automatic string cmd_text(draw_cmd_type c);
      return $sformatf("kind=%0d x=%0d y=%0d color=%0d gain=%0d led=%0d last=%0d",
                       c.kind, c.x, c.y, c.color, c.gain, c.led, c.last);
   endfunction

   task automatic plot_sample(input logic [stp_pkg::SAMPLE_W-1:0] s,
                              input logic [stp_pkg::GAIN_W-1:0] g);
      draw_cmd_type                cmds[$];
      int                          x, new_y, old_y, nxt, led_word;
      logic [stp_pkg::COLOR_W-1:0] erase_c;
      if (!running || g != gain_held) begin
         gain_held = g;
         sweep     = 0;
         running   = 1'b1;
         cmds.push_back(make_cmd(stp_pkg::CMD_CLEAR, 0, 0, bg_c));
      end
      if (sweep >= COLUMNS) sweep = 0;
      x     = sweep;
      new_y = (ROWS - 1) - int'(s) / SAMPLE_DIV;
      if (new_y < 0) new_y = 0;
      if (new_y > ROWS - 1) new_y = ROWS - 1;
      old_y = int'(col_row[x]);
      if (old_y % (ROWS / 8) == 0) erase_c = grid_c;
      else if (old_y == ROWS / 2) erase_c = axis_c;
      else erase_c = bg_c;
      cmds.push_back(make_cmd(stp_pkg::CMD_PIXEL, x, old_y, erase_c));
      if (x % (COLUMNS / 10) == 0) cmds.push_back(make_cmd(stp_pkg::CMD_VLINE, x, 0, grid_c));
      if (x == COLUMNS / 2) cmds.push_back(make_cmd(stp_pkg::CMD_VLINE, x, 0, axis_c));
      cmds.push_back(make_cmd(stp_pkg::CMD_PIXEL, x, new_y, trace_c));
      col_row[x] = new_y[YW-1:0];
      nxt = (x + 1 >= COLUMNS) ? 0 : x + 1;
      sweep = nxt;
      led_word = (int'(gain_held) << 4) | (nxt >> 5);
      foreach (cmds[i]) begin
         cmds[i].gain = gain_held;
         cmds[i].led  = led_word[stp_pkg::LED_W-1:0];
         cmds[i].last = (i == cmds.size() - 1);
         expected_cmds.push_back(cmds[i]);
      end
   endtask

   always @(posedge clock) begin
      draw_cmd_type want, got;
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) col_row[i] = YW'(ROWS / 2);
         sweep     = 0;
         gain_held = '0;
         running   = 1'b0;
         trace_c   = stp_pkg::TRACE_COLOR_RESET;
         grid_c    = stp_pkg::GRID_COLOR_RESET;
         axis_c    = stp_pkg::AXIS_COLOR_RESET;
         bg_c      = stp_pkg::BACKGROUND_COLOR_RESET;
         expected_cmds.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (stp_pkg::reg_index_type'(paddr[3:2]))
               stp_pkg::REG_TRACE_COLOR:      trace_c = pwdata[stp_pkg::COLOR_W-1:0];
               stp_pkg::REG_GRID_COLOR:       grid_c  = pwdata[stp_pkg::COLOR_W-1:0];
               stp_pkg::REG_AXIS_COLOR:       axis_c  = pwdata[stp_pkg::COLOR_W-1:0];
               stp_pkg::REG_BACKGROUND_COLOR: bg_c    = pwdata[stp_pkg::COLOR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) plot_sample(req_adc_sample, req_gain_code);
         if (rsp_valid && !rsp_stall) begin
            got = {stp_pkg::cmd_kind_type'(rsp_cmd_kind), rsp_pos_x, rsp_pos_y, rsp_color,
                   rsp_gain_out, rsp_led_value, rsp_last_cmd};
            if (expected_cmds.size() == 0) begin
               errs++;
               if (errs <= 10) $display("unexpected command beat: %s", cmd_text(got));
            end else begin
               want = expected_cmds.pop_front();
               if (want !== got) begin
                  errs++;
                  if (errs <= 10)
                     $display("command mismatch: expected %s, got %s",
                              cmd_text(want), cmd_text(got));
               end
            end
         end
      end
      pending_cmds <= expected_cmds.size();
      fail_count   <= errs;
   end

endmodule

### verif/tb_scope_trace_plotter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scope_trace_plotter_core
// Drives samples and gain codes into the trace plotter, programs the colour
// registers between phases and stalls the command side, while a checker
// beside the block predicts every draw command. Directed samples cover the
// row extremes and gain changes; random runs follow, the last one sweeping
// past the centre axis under receiver backpressure that fills the block.
// ----------------------------------------------------------------------------
module tb_scope_trace_plotter_core;

   localparam int COLUMNS = stp_pkg::COLUMNS_DEFAULT;
   localparam int ROWS    = stp_pkg::ROWS_DEFAULT;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [stp_pkg::SAMPLE_W-1:0]      req_adc_sample;
   logic [stp_pkg::GAIN_W-1:0]        req_gain_code;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [stp_pkg::KIND_W-1:0]        rsp_cmd_kind;
   logic [$clog2(COLUMNS)-1:0]        rsp_pos_x;
   logic [$clog2(ROWS)-1:0]           rsp_pos_y;
   logic [stp_pkg::COLOR_W-1:0]       rsp_color;
   logic [stp_pkg::GAIN_W-1:0]        rsp_gain_out;
   logic [stp_pkg::LED_W-1:0]         rsp_led_value;
   logic                              rsp_last_cmd;
   logic                              psel, penable, pwrite, pready;
   logic [stp_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [stp_pkg::CSR_DATA_W-1:0]    pwdata, prdata;

   int                          fail_count, pending_cmds;
   int                          tx_idle_pct, rx_idle_pct;
   bit                          hold_req, hold_served;
   logic [stp_pkg::GAIN_W-1:0]  run_gain;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   scope_trace_plotter_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

   scope_trace_plotter_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) plot_check (
      .clock, .reset, .req_valid, .req_stall, .req_adc_sample, .req_gain_code,
      .rsp_valid, .rsp_stall, .rsp_cmd_kind, .rsp_pos_x, .rsp_pos_y, .rsp_color,
      .rsp_gain_out, .rsp_led_value, .rsp_last_cmd,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending_cmds
   );

   // command side: random stall, plus one long hold-off on request
   initial begin
      rsp_stall   = 1'b0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_scope_trace_plotter_core failed");
      $finish;
   end

   task automatic send_sample(input logic [stp_pkg::SAMPLE_W-1:0] s,
                              input logic [stp_pkg::GAIN_W-1:0] g);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= s;
      req_gain_code  <= g;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cmds != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_colors(input logic [7:0] trace_v, input logic [7:0] grid_v,
                             input logic [7:0] axis_v, input logic [7:0] bg_v);
      logic [7:0] vals [4];
      vals = '{trace_v, grid_v, axis_v, bg_v};
      for (int i = 0; i < 4; i++) begin
         psel    <= 1'b1;
         pwrite  <= 1'b1;
         penable <= 1'b0;
         paddr   <= {stp_pkg::reg_index_type'(i), 2'b00};
         pwdata  <= {24'd0, vals[i]};
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [stp_pkg::SAMPLE_W-1:0] pick_sample();
      int s;
      case ($urandom_range(3))
         0: s = $urandom_range(300);
         1: s = 65535 - $urandom_range(400);
         2: s = (239 - 30 * $urandom_range(7)) * 274 + $urandom_range(273);
         default: s = $urandom_range(65535);
      endcase
      if (s > 65535) s = 65535;
      return s[stp_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic random_run(input int n, input int change_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < change_pct) run_gain = stp_pkg::GAIN_W'($urandom_range(7));
         send_sample(pick_sample(), run_gain);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_adc_sample = '0;
      req_gain_code  = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      hold_req       = 1'b0;
      tx_idle_pct    = 6;
      rx_idle_pct    = 78;
      run_gain       = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset colours; row extremes, clamp edges and gain changes
      send_sample(16'd0, 3'd0);
      send_sample(16'hFFFF, 3'd0);
      send_sample(16'd65486, 3'd0);
      send_sample(16'd65485, 3'd0);
      send_sample(16'd273, 3'd0);
      send_sample(16'd274, 3'd0);
      send_sample(16'hAAAA, 3'd0);
      send_sample(16'h5555, 3'd0);
      send_sample(16'd32606, 3'd0);
      send_sample(16'd32879, 3'd0);
      send_sample(16'hFFFF, 3'd7);
      send_sample(16'd57266, 3'd7);
      send_sample(16'd1000, 3'd7);
      send_sample(16'h8000, 3'd5);
      send_sample(16'h7FFF, 3'd5);
      send_sample(16'h1234, 3'd2);
      send_sample(16'hEDCB, 3'd2);
      send_sample(16'd0, 3'd7);
      send_sample(16'd65535, 3'd0);
      send_sample(16'd8220, 3'd0);
      settle();

      set_colors(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_gain = stp_pkg::GAIN_W'($urandom_range(7));
      random_run(15, 4);
      settle();

      tx_idle_pct = 78;
      rx_idle_pct = 6;
      set_colors(8'h00, 8'h00, 8'h00, 8'h00);
      random_run(15, 4);
      settle();

      // no idling; long hold-off backs the block up, then a sweep past the axis
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_colors(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      hold_req = 1'b1;
      run_gain = run_gain + stp_pkg::GAIN_W'(1);
      random_run(165, 0);
      settle();
      repeat (16) @(posedge clock);

      if (fail_count == 0) $display("tb_scope_trace_plotter_core passed");
      else $display("tb_scope_trace_plotter_core failed");
      $finish;
   end

endmodule
